// File: rtl/sorted_set_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Sorted set engine assertion macros
// Concurrent check wrappers on clk and rst_n, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_ENGINE_CORE_DEFINES_SVH
`define SORTED_SET_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds at every edge out of reset.
`define SSE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sse check failed");
// Antecedent implies consequent in the same cycle.
`define SSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sse check failed");
// Antecedent implies consequent in the next cycle.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sse check failed");
`else
`define SSE_ASSERT_ALWAYS(lbl, cond)
`define SSE_ASSERT_SAME(lbl, ante, cons)
`define SSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set engine package
// Field widths, operation and status codes, cell control type.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int OPCODE_W    = 2;
  localparam int KEY_IN_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;  // compare own key with request, register flags
    logic ins;  // open a slot and drop the request key in
    logic rem;  // close the gap at the hit cell
  } cell_ctl_t;

endpackage

// File: rtl/sse_req_if.sv
// ----------------------------------------------------------------------------
// Sorted set engine request channel
// Valid/ready channel carrying opcode and key.
// ----------------------------------------------------------------------------
interface sse_req_if;
  logic                          valid;
  logic                          ready;
  logic [sse_pkg::OPCODE_W-1:0]  opcode;
  logic [sse_pkg::KEY_IN_W-1:0]  key;

  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

// File: rtl/sse_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted set engine result channel
// Valid/ready channel carrying status, found flag and count.
// ----------------------------------------------------------------------------
interface sse_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sse_pkg::STATUS_W-1:0]     status;
  logic                             found;
  logic [sse_pkg::COUNT_OUT_W-1:0]  count;

  modport source (output valid, status, found, count, input ready);
  modport sink   (input valid, status, found, count, output ready);
endinterface

// File: rtl/sse_cell.sv
// ----------------------------------------------------------------------------
// Sorted set engine cell
// One key slot with its compare and its shift mux toward both neighbors.
// ----------------------------------------------------------------------------
module sse_cell #(
  parameter int KEY_WIDTH = sse_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sse_pkg::cell_ctl_t    ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic                  cmp_signed,
  input  logic [KEY_WIDTH-1:0]  req_key,
  input  logic [KEY_WIDTH-1:0]  req_ov,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic                  left_ge,
  input  logic [KEY_WIDTH-1:0]  right_key,
  output logic [KEY_WIDTH-1:0]  key_q,
  output logic                  ge_q,
  output logic                  eq_q
);
  import sse_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic [KEY_WIDTH-1:0] own_ov;
  logic                 ge_r;
  logic                 eq_r;
  logic                 occ;

  assign occ    = MY_IDX < count;
  assign own_ov = key_r ^ (KEY_WIDTH'(cmp_signed) << (KEY_WIDTH - 1));

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      // keys at and above the slot move up one place
      if (left_ge) begin
        key_nxt = left_key;
      end else if (ge_r || (MY_IDX == count)) begin
        key_nxt = req_key;
      end
    end else if (ctl.rem) begin
      if (ge_r) begin
        key_nxt = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      ge_r <= occ && (own_ov >= req_ov);
      eq_r <= occ && (own_ov == req_ov);
    end
  end

  assign key_q = key_r;
  assign ge_q  = ge_r;
  assign eq_q  = eq_r;

endmodule

// File: rtl/sse_chain.sv
// ----------------------------------------------------------------------------
// Sorted set engine cell chain
// Row of key cells wired to their neighbors, with the hit reduction.
// ----------------------------------------------------------------------------
module sse_chain #(
  parameter int CAPACITY  = sse_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = sse_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sse_pkg::cell_ctl_t    ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic                  cmp_signed,
  input  logic [KEY_WIDTH-1:0]  req_key,
  input  logic [KEY_WIDTH-1:0]  req_ov,
  output logic [CAPACITY-1:0]   eq_vec,
  output logic                  hit
);
  import sse_pkg::*;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  ge_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_ge;
    logic [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = req_key;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_ge  = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sse_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count),
      .cmp_signed (cmp_signed),
      .req_key    (req_key),
      .req_ov     (req_ov),
      .left_key   (left_key),
      .left_ge    (left_ge),
      .right_key  (right_key),
      .key_q      (cell_key[i]),
      .ge_q       (ge_vec[i]),
      .eq_q       (eq_vec[i])
    );
  end

  assign hit = |eq_vec;

endmodule

// File: rtl/sorted_set_engine_core.sv
// ----------------------------------------------------------------------------
// Sorted set engine core
// Ordered set of distinct keys held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------
//  in_ch    | in  | valid / ready     | opcode[1:0], key[31:0]
//  out_ch   | out | valid / ready     | status[1:0], found, count[6:0]
//  cfg      | in  | cfg_we            | cfg_wdata (compare_signed)
//
//  An item goes through accept, compare in every cell at once, then
//  update (shift the chain and load the result register). The update step
//  of the shared control sets the rate: one item in flight at a time.
//  A result waiting in the output register holds the next item in its
//  update step until out_ch.ready. Reset clears the count and the order
//  select; key slots are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_set_engine_core_defines.svh"

module sorted_set_engine_core #(
  parameter int CAPACITY  = sse_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = sse_pkg::KEY_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sse_req_if.sink    in_ch,
  sse_rsp_if.source  out_ch,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);
  import sse_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t                state_r;
  logic                  cmp_signed_r;
  logic [OPCODE_W-1:0]   op_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r;
  logic [STATUS_W-1:0]   status_nxt;
  logic                  found_r;
  logic                  found_nxt;

  logic [KEY_WIDTH-1:0]  req_ov;
  logic [CAPACITY-1:0]   eq_vec;
  logic                  hit;
  logic                  upd_go;
  logic                  in_acc;
  cell_ctl_t             ctl;

  // Flip the sign bit so an unsigned compare gives signed order
  assign req_ov = key_r ^ (KEY_WIDTH'(cmp_signed_r) << (KEY_WIDTH - 1));

  assign in_acc = in_ch.valid && in_ch.ready;
  // Advance out of update only when the result register is free
  assign upd_go = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl        = '0;
    ctl.cmp    = (state_r == S_CMP);
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    found_nxt  = hit;
    case (op_r)
      OP_INSERT: begin
        if (hit) begin
          status_nxt = ST_MISS;
        end else if (count_r == CNT_FULL) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins   = upd_go;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_MISS;
        end else begin
          ctl.rem   = upd_go;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // find, and the unused code, leave the set untouched
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_signed_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cmp_signed_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: hold request and result without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.opcode;
      key_r <= KEY_WIDTH'(in_ch.key);
    end
    if (upd_go) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
  end

  sse_chain #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .count      (count_r),
    .cmp_signed (cmp_signed_r),
    .req_key    (key_r),
    .req_ov     (req_ov),
    .eq_vec     (eq_vec),
    .hit        (hit)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.found  = found_r;
  assign out_ch.count  = COUNT_OUT_W'(count_r);

  // Distinct keys: at most one cell can match
  `SSE_ASSERT_ALWAYS(a_hit_onehot, $onehot0(eq_vec))
  `SSE_ASSERT_ALWAYS(a_count_cap, count_r <= CNT_FULL)
  `SSE_ASSERT_NEXT(a_ins_grows, ctl.ins, count_r == $past(count_r) + CNT_W'(1))
  `SSE_ASSERT_NEXT(a_rem_shrinks, ctl.rem, count_r == $past(count_r) - CNT_W'(1))
  `SSE_ASSERT_SAME(a_result_from_upd, $rose(out_valid_r), $past(state_r) == S_UPD)

endmodule

// File: dv/sorted_set_engine_core_checker.sv
// ----------------------------------------------------------------------------
// Sorted set engine result checker
// Tracks the held key set from every accepted request and the order select
// written on the configuration port, and checks each accepted result against
// the oldest outstanding outcome, field by field.
// ----------------------------------------------------------------------------
module sorted_set_engine_core_checker
  import sse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sse_req_if          req_mon,
  sse_rsp_if          rsp_mon,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int unsigned mismatches,
  output int unsigned awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] count;
  } set_outcome_t;

  logic [KEY_IN_W-1:0] held_keys [CAPACITY_DEF];
  int unsigned         held_count;
  logic                order_signed;
  set_outcome_t        outcome_q [$];

  // Flip the sign bit so a plain unsigned compare follows the selected order.
  function automatic logic [KEY_IN_W-1:0] rank(input logic [KEY_IN_W-1:0] k);
    return order_signed ? {~k[KEY_IN_W-1], k[KEY_IN_W-2:0]} : k;
  endfunction

  // First held slot whose key is not below k.
  function automatic int unsigned find_slot(input logic [KEY_IN_W-1:0] k, output bit hit);
    int unsigned i;
    hit = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (rank(held_keys[i]) >= rank(k)) begin
        hit = (held_keys[i] == k);
        return i;
      end
    end
    return held_count;
  endfunction

  function automatic set_outcome_t apply_request(input logic [OPCODE_W-1:0] op,
                                                 input logic [KEY_IN_W-1:0] k);
    set_outcome_t res;
    int unsigned  slot;
    int unsigned  i;
    bit           hit;
    res.status = ST_DONE;
    slot = find_slot(k, hit);
    if (op == OP_INSERT) begin
      if (hit) begin
        res.status = ST_MISS;
      end else if (held_count >= CAPACITY_DEF) begin
        res.status = ST_FULL;
      end else begin
        for (i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
        held_keys[slot] = k;
        held_count++;
      end
    end else if (op == OP_REMOVE) begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else if (!hit) begin
        res.status = ST_MISS;
      end else begin
        for (i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end
    end
    // find and the spare opcode leave the set alone
    res.found = hit;
    res.count = held_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    set_outcome_t want;
    if (!rst_n) begin
      held_count   = 0;
      order_signed = 1'b0;
      outcome_q.delete();
      mismatches   = 0;
    end else begin
      if (cfg_we) order_signed = cfg_wdata;
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d found %0d count %0d",
                   $time, rsp_mon.status, rsp_mon.found, rsp_mon.count);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_mon.status));
          compare_field("found",  32'(want.found),  32'(rsp_mon.found));
          compare_field("count",  32'(want.count),  32'(rsp_mon.count));
        end
      end
      if (req_mon.valid && req_mon.ready)
        outcome_q.push_back(apply_request(req_mon.opcode, req_mon.key));
    end
    awaiting = outcome_q.size();
  end

endmodule

// File: dv/sorted_set_engine_core_test.sv
// ----------------------------------------------------------------------------
// Sorted set engine core testbench
// Drives requests with random gaps and result stalls against the core, runs
// directed corner items then pool-based random phases under both key orders,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module sorted_set_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sse_pkg::*;

  // Opcode 3 has no name in the package; the core treats it as a find.
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  localparam int unsigned POOL_SIZE      = 72;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  sse_req_if in_ch ();
  sse_rsp_if out_ch ();

  int unsigned         mismatches;
  int unsigned         awaiting;
  int unsigned         idle_cycles;
  bit                  quiet;
  logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
  int unsigned         insert_cursor;

  always #10 clk = ~clk;

  sorted_set_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sorted_set_engine_core_checker u_set_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Idle length for either side: mostly none, some short, a few long.
  // Quiet stretches run back to back with no idling at all.
  function automatic int unsigned hold_off();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Build a fresh key pool: the extremes of both orders, then random keys.
  function automatic void refill_pool();
    int unsigned i;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'hFFFF_FFFE;
    key_pool[6] = 32'h8000_0001;
    key_pool[7] = 32'h7FFF_FFFE;
    for (i = 8; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    insert_cursor = $urandom_range(POOL_SIZE - 1);
  endfunction

  // Result side: stall ready at random, changing only on the falling edge.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0) stall = hold_off();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Hold an item on the request channel until it is taken. Keep valid high
  // across back-to-back items so it is assigned once per edge.
  task automatic send(input logic [OPCODE_W-1:0] op, input logic [KEY_IN_W-1:0] k);
    int unsigned gap;
    gap = hold_off();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid  <= 1'b0;
      in_ch.opcode <= OPCODE_W'($urandom_range(3));
      in_ch.key    <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= k;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_order(input logic order_signed);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= order_signed;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random mix over the pool. Inserts walk the pool so the set fills up;
  // other requests pick pool keys mostly and stray keys now and then.
  task automatic mixed_run(input int unsigned n, input int unsigned w_ins,
                           input int unsigned w_rem);
    int unsigned         i;
    int unsigned         r;
    logic [KEY_IN_W-1:0] k;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      if (r < w_ins) begin
        send(OP_INSERT, key_pool[insert_cursor]);
        insert_cursor = (insert_cursor + 1) % POOL_SIZE;
      end else if (r < w_ins + w_rem) begin
        send(OP_REMOVE, k);
      end else if (r < 95) begin
        send(OP_FIND, k);
      end else begin
        send(OP_SPARE, k);
      end
    end
  endtask

  // Empty the set: remove every pool key, then hit the empty set a few times.
  task automatic sweep_pool();
    int unsigned i;
    for (i = 0; i < POOL_SIZE; i++) send(OP_REMOVE, key_pool[i]);
    repeat (3) send(OP_REMOVE, $urandom);
  endtask

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned setting;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_FIND;
    in_ch.key    = '0;
    quiet        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners, unsigned order: empty set, extremes, duplicate,
    // misses, the spare opcode, and draining back to empty.
    write_order(1'b0);
    send(OP_FIND,   32'h0000_0000);
    send(OP_REMOVE, 32'h0000_0005);
    send(OP_INSERT, 32'h7FFF_FFFF);
    send(OP_INSERT, 32'h8000_0000);
    send(OP_INSERT, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'h0000_0000);
    send(OP_INSERT, 32'h0000_0000);
    send(OP_FIND,   32'hFFFF_FFFF);
    send(OP_FIND,   32'h1234_5678);
    send(OP_SPARE,  32'h8000_0000);
    send(OP_SPARE,  32'h0000_0001);
    send(OP_REMOVE, 32'h1234_5678);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_REMOVE, 32'h0000_0000);
    send(OP_REMOVE, 32'hFFFF_FFFF);
    send(OP_REMOVE, 32'h7FFF_FFFF);
    send(OP_REMOVE, 32'h7FFF_FFFF);
    settle();

    // Same extremes under signed order: negative keys now sort first.
    write_order(1'b1);
    send(OP_INSERT, 32'h0000_0000);
    send(OP_INSERT, 32'h7FFF_FFFF);
    send(OP_INSERT, 32'h8000_0000);
    send(OP_INSERT, 32'hFFFF_FFFF);
    send(OP_FIND,   32'h8000_0000);
    send(OP_REMOVE, 32'hFFFF_FFFF);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_REMOVE, 32'h7FFF_FFFF);
    send(OP_REMOVE, 32'h0000_0000);

    // Random phases per order: fill past full, churn, then drain to empty.
    // The set is always empty before the order changes.
    for (setting = 0; setting < 4; setting++) begin
      settle();
      write_order(setting[0]);
      refill_pool();
      quiet = 1'b0;
      mixed_run(160, 75, 10);
      quiet = setting[0];
      mixed_run(130, 35, 35);
      quiet = 1'b0;
      mixed_run(60, 15, 60);
      sweep_pool();
    end

    settle();
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
